[rtl/dfsec_pkg.sv]
package dfsec_pkg;

    // Fixed field widths of the words on both channels
    localparam int VID_W   = 3;
    localparam int COUNT_W = 4;
    localparam int DEPTH_W = 4;

    // Opcodes of the input word
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_LOAD,
        ST_SCAN,
        ST_POP,
        ST_FINISH
    } dfsec_state_t;

    typedef struct packed {
        logic [VID_W-1:0]   from_vertex;
        logic [VID_W-1:0]   to_vertex;
        logic               tree_edge;
        logic [DEPTH_W-1:0] depth_level;
        logic               root_group_end;
        logic               last;
    } dfsec_rec_t;

    // Walker requests toward the adjacency store
    typedef struct packed {
        logic rd_en;
        logic clear;
    } dfsec_walk_ctl_t;

endpackage

[rtl/dfsec_if.sv]
interface dfsec_in_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [dfsec_pkg::VID_W-1:0]     src_vertex;
    logic [dfsec_pkg::VID_W-1:0]     dst_vertex;
    logic [dfsec_pkg::COUNT_W-1:0]   vertex_count;

    modport source (
        output valid, opcode, src_vertex, dst_vertex, vertex_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, src_vertex, dst_vertex, vertex_count,
        output ready
    );
endinterface

interface dfsec_out_if;
    logic                            valid;
    logic                            ready;
    logic [dfsec_pkg::VID_W-1:0]     from_vertex;
    logic [dfsec_pkg::VID_W-1:0]     to_vertex;
    logic                            tree_edge;
    logic [dfsec_pkg::DEPTH_W-1:0]   depth_level;
    logic                            root_group_end;
    logic                            last;

    modport source (
        output valid, from_vertex, to_vertex, tree_edge, depth_level,
               root_group_end, last,
        input  ready
    );
    modport sink (
        input  valid, from_vertex, to_vertex, tree_edge, depth_level,
               root_group_end, last,
        output ready
    );
endinterface

[rtl/dfsec_adj_store.sv]
// Adjacency matrix: one row per source vertex in a synchronous RAM.
// Edge loads are a two-stage read-modify-write with one-entry forwarding.
// Row valid bits make a never-written or cleared row read as zero.
module dfsec_adj_store #(
    parameter int  MAX_VERTICES = 8,
    localparam int VTX_W = $clog2(MAX_VERTICES)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            edge_en,
    input  logic [dfsec_pkg::VID_W-1:0]     src_vertex,
    input  logic [dfsec_pkg::VID_W-1:0]     dst_vertex,
    input  dfsec_pkg::dfsec_walk_ctl_t      walk_ctl,
    input  logic [VTX_W-1:0]                walk_addr,
    output logic [MAX_VERTICES-1:0]         row
);

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic                    s2_valid_reg;
    logic [VTX_W-1:0]        s2_src_reg;
    logic [VTX_W-1:0]        s2_dst_reg;
    logic                    fwd_valid_reg;
    logic [VTX_W-1:0]        fwd_addr_reg;
    logic [MAX_VERTICES-1:0] fwd_row_reg;
    logic [MAX_VERTICES-1:0] rd_data_reg;
    logic                    rd_valid_reg;

    logic                    in_range;
    logic                    load_en;
    logic                    rd_en;
    logic [VTX_W-1:0]        rd_addr;
    logic [MAX_VERTICES-1:0] base_row;
    logic [MAX_VERTICES-1:0] new_row;

    assign in_range = (32'(src_vertex) < 32'(MAX_VERTICES))
                   && (32'(dst_vertex) < 32'(MAX_VERTICES));
    assign load_en  = edge_en && in_range;
    assign rd_en    = walk_ctl.rd_en || load_en;
    assign rd_addr  = walk_ctl.rd_en ? walk_addr : VTX_W'(src_vertex);

    // Row written last cycle is not yet visible at the read port
    assign base_row = (fwd_valid_reg && (fwd_addr_reg == s2_src_reg)) ? fwd_row_reg
                    : (rd_valid_reg ? rd_data_reg : '0);
    assign new_row  = base_row | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << s2_dst_reg);

    assign row = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (walk_ctl.clear)
        begin
            row_valid_next = '0;
        end
        else if (s2_valid_reg)
        begin
            row_valid_next[s2_src_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            s2_valid_reg  <= load_en;
            fwd_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            adj_mem[s2_src_reg] <= new_row;
        end
        if (rd_en)
        begin
            rd_data_reg  <= adj_mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (load_en)
        begin
            s2_src_reg <= VTX_W'(src_vertex);
            s2_dst_reg <= VTX_W'(dst_vertex);
        end
        fwd_addr_reg <= s2_src_reg;
        fwd_row_reg  <= new_row;
    end

endmodule

[rtl/dfs_edge_classifier.sv]
// Depth-first edge classifier. Add-edge words set one bit of an adjacency
// matrix and are taken one per cycle; a duplicate edge is absorbed. A run
// word walks the graph depth-first from every unvisited root below
// min(vertex_count, MAX_VERTICES), neighbors in ascending order, and sends
// one output word per examined edge; the last word of the run carries last.
// A run with no edges sends nothing. After the run the matrix and visited
// marks clear together and the block takes words again. The run is slowed
// by output backpressure, and every step waits for the single read port
// of the adjacency RAM; returning from a descent also waits on the walk
// stack RAM read. No input word is taken during a run. The output holds
// one word in a register and one more ahead of it, so the final word can
// be flagged.
module dfs_edge_classifier #(
    parameter int MAX_VERTICES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    dfsec_in_if.sink         in_ch,
    dfsec_out_if.source      out_ch
);

    localparam int VTX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int STK_W = VTX_W + CNT_W;

    // FSM and walk state
    dfsec_pkg::dfsec_state_t state_reg, state_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        root_reg, root_next;
    logic [CNT_W-1:0]        sp_reg, sp_next;
    logic [VTX_W-1:0]        top_vertex_reg, top_vertex_next;
    logic [CNT_W-1:0]        top_next_reg, top_next_next;
    logic [MAX_VERTICES-1:0] top_row_reg, top_row_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;

    // Output staging: pending word, then output register
    dfsec_pkg::dfsec_rec_t   pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;
    dfsec_pkg::dfsec_rec_t   out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    // Walk stack RAM: parent vertex and its resume index
    logic [STK_W-1:0]        stack_mem [MAX_VERTICES];
    logic [STK_W-1:0]        stack_rd_reg;
    logic                    stack_wr_en, stack_rd_en;
    logic [VTX_W-1:0]        stack_wr_addr, stack_rd_addr;
    logic [STK_W-1:0]        stack_wr_data;

    // Adjacency store interface
    logic                        edge_en;
    dfsec_pkg::dfsec_walk_ctl_t  walk_ctl;
    logic [VTX_W-1:0]            walk_addr;
    logic [MAX_VERTICES-1:0]     adj_row;

    // Neighbor search on the cached row
    logic [MAX_VERTICES-1:0] masked, lowest, rest;
    logic [VTX_W-1:0]        w_idx;
    logic                    found, is_last, tree;
    logic [VTX_W-1:0]        root_idx;
    logic [CNT_W-1:0]        sp_dec1, sp_dec2;

    logic in_acc, out_free, can_emit, root_live, push_ok;
    dfsec_pkg::dfsec_rec_t   rec;

    dfsec_adj_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_en    (edge_en),
        .src_vertex (in_ch.src_vertex),
        .dst_vertex (in_ch.dst_vertex),
        .walk_ctl   (walk_ctl),
        .walk_addr  (walk_addr),
        .row        (adj_row)
    );

    assign in_ch.ready = (state_reg == dfsec_pkg::ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign can_emit    = !pend_valid_reg || out_free;

    assign root_idx  = root_reg[VTX_W-1:0];
    assign root_live = (root_reg < n_reg);
    assign sp_dec1   = sp_reg - CNT_W'(1);
    assign sp_dec2   = sp_reg - CNT_W'(2);

    // Lowest set bit at or above the resume index, and whether another follows
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            masked[i] = top_row_reg[i] && (CNT_W'(i) >= top_next_reg);
        end
        lowest = masked & (~masked + {{(MAX_VERTICES-1){1'b0}}, 1'b1});
        rest   = masked ^ lowest;
        w_idx  = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (lowest[i])
            begin
                w_idx = w_idx | VTX_W'(i);
            end
        end
        found   = |masked;
        is_last = ~|rest;
    end

    assign tree    = !visited_reg[w_idx];
    assign push_ok = tree && (sp_reg < CNT_W'(MAX_VERTICES));

    always_comb
    begin
        rec.from_vertex    = dfsec_pkg::VID_W'(top_vertex_reg);
        rec.to_vertex      = dfsec_pkg::VID_W'(w_idx);
        rec.tree_edge      = tree;
        rec.depth_level    = dfsec_pkg::DEPTH_W'(sp_reg);
        rec.root_group_end = (sp_reg == CNT_W'(1)) && is_last;
        rec.last           = 1'b0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dfsec_pkg::ST_IDLE:
            begin
                if (in_acc && (in_ch.opcode == dfsec_pkg::OP_RUN))
                begin
                    state_next = dfsec_pkg::ST_ROOT;
                end
            end
            dfsec_pkg::ST_ROOT:
            begin
                if (!root_live)
                begin
                    state_next = dfsec_pkg::ST_FINISH;
                end
                else if (!visited_reg[root_idx])
                begin
                    state_next = dfsec_pkg::ST_LOAD;
                end
            end
            dfsec_pkg::ST_LOAD:
            begin
                state_next = dfsec_pkg::ST_SCAN;
            end
            dfsec_pkg::ST_SCAN:
            begin
                if (!found)
                begin
                    state_next = (sp_reg == CNT_W'(1)) ? dfsec_pkg::ST_ROOT
                                                       : dfsec_pkg::ST_POP;
                end
                else if (can_emit && push_ok)
                begin
                    state_next = dfsec_pkg::ST_LOAD;
                end
            end
            dfsec_pkg::ST_POP:
            begin
                state_next = dfsec_pkg::ST_LOAD;
            end
            dfsec_pkg::ST_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = dfsec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dfsec_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        n_next          = n_reg;
        root_next       = root_reg;
        sp_next         = sp_reg;
        top_vertex_next = top_vertex_reg;
        top_next_next   = top_next_reg;
        top_row_next    = top_row_reg;
        visited_next    = visited_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        edge_en         = 1'b0;
        walk_ctl        = '0;
        walk_addr       = top_vertex_reg;
        stack_wr_en     = 1'b0;
        stack_wr_addr   = sp_dec1[VTX_W-1:0];
        stack_wr_data   = {top_vertex_reg, CNT_W'(w_idx) + CNT_W'(1)};
        stack_rd_en     = 1'b0;
        stack_rd_addr   = sp_dec2[VTX_W-1:0];

        case (state_reg)
            dfsec_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.opcode == dfsec_pkg::OP_ADD_EDGE)
                    begin
                        edge_en = 1'b1;
                    end
                    else
                    begin
                        // vertex count saturates at the matrix size
                        if (32'(in_ch.vertex_count) > 32'(MAX_VERTICES))
                        begin
                            n_next = CNT_W'(MAX_VERTICES);
                        end
                        else
                        begin
                            n_next = CNT_W'(in_ch.vertex_count);
                        end
                        root_next = '0;
                    end
                end
            end
            dfsec_pkg::ST_ROOT:
            begin
                if (root_live)
                begin
                    root_next = root_reg + CNT_W'(1);
                    if (!visited_reg[root_idx])
                    begin
                        visited_next[root_idx] = 1'b1;
                        sp_next                = CNT_W'(1);
                        top_vertex_next        = root_idx;
                        top_next_next          = '0;
                        walk_ctl.rd_en         = 1'b1;
                        walk_addr              = root_idx;
                    end
                end
            end
            dfsec_pkg::ST_LOAD:
            begin
                top_row_next = adj_row;
            end
            dfsec_pkg::ST_SCAN:
            begin
                if (!found)
                begin
                    // row exhausted: pop, fetch parent unless this was the root
                    sp_next = sp_dec1;
                    if (sp_reg != CNT_W'(1))
                    begin
                        stack_rd_en = 1'b1;
                    end
                end
                else if (can_emit)
                begin
                    pend_next       = rec;
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    top_next_next = CNT_W'(w_idx) + CNT_W'(1);
                    if (push_ok)
                    begin
                        stack_wr_en         = 1'b1;
                        visited_next[w_idx] = 1'b1;
                        sp_next             = sp_reg + CNT_W'(1);
                        top_vertex_next     = w_idx;
                        top_next_next       = '0;
                        walk_ctl.rd_en      = 1'b1;
                        walk_addr           = w_idx;
                    end
                end
            end
            dfsec_pkg::ST_POP:
            begin
                top_vertex_next = stack_rd_reg[STK_W-1:CNT_W];
                top_next_next   = stack_rd_reg[CNT_W-1:0];
                walk_ctl.rd_en  = 1'b1;
                walk_addr       = stack_rd_reg[STK_W-1:CNT_W];
            end
            dfsec_pkg::ST_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    walk_ctl.clear  = 1'b1;
                    visited_next    = '0;
                    sp_next         = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dfsec_pkg::ST_IDLE;
            sp_reg         <= '0;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        root_reg       <= root_next;
        top_vertex_reg <= top_vertex_next;
        top_next_reg   <= top_next_next;
        top_row_reg    <= top_row_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_wr_en)
        begin
            stack_mem[stack_wr_addr] <= stack_wr_data;
        end
        if (stack_rd_en)
        begin
            stack_rd_reg <= stack_mem[stack_rd_addr];
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.from_vertex    = out_reg.from_vertex;
    assign out_ch.to_vertex      = out_reg.to_vertex;
    assign out_ch.tree_edge      = out_reg.tree_edge;
    assign out_ch.depth_level    = out_reg.depth_level;
    assign out_ch.root_group_end = out_reg.root_group_end;
    assign out_ch.last           = out_reg.last;

endmodule

[dv/dfsec_walk_checker.sv]
`timescale 1ns / 100ps

module dfsec_walk_checker #(
    parameter int NV = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    dfsec_in_if     in_ch,
    dfsec_out_if    out_ch,
    output int      fail_count,
    output int      pending
);

    // Shadow graph and walk state
    logic [NV-1:0]  edge_rows [NV];
    logic [NV-1:0]  seen_mask;
    int             walk_vtx [NV];
    int             walk_nxt [NV];

    dfsec_pkg::dfsec_rec_t expected_edges [$];
    dfsec_pkg::dfsec_rec_t got;
    dfsec_pkg::dfsec_rec_t want;
    int                    words_seen;

    function automatic int lowest_neighbor(input logic [NV-1:0] row, input int start);
        for (int w = start; w < NV; w++)
        begin
            if (row[w])
                return w;
        end
        return NV;
    endfunction

    // Depth-first walk over the shadow graph; queues one record per examined edge.
    // The newest record is held back so the final one can get its last flag.
    task automatic walk_graph(input logic [dfsec_pkg::COUNT_W-1:0] count);
        int                    roots;
        int                    sp;
        int                    u;
        int                    w;
        bit                    is_tree;
        bit                    is_end;
        bit                    have_held;
        dfsec_pkg::dfsec_rec_t held;
        dfsec_pkg::dfsec_rec_t rec;
        roots = (count > NV) ? NV : int'(count);
        have_held = 1'b0;
        for (int r = 0; r < roots; r++)
        begin
            if (!seen_mask[r])
            begin
                seen_mask[r] = 1'b1;
                walk_vtx[0] = r;
                walk_nxt[0] = 0;
                sp = 1;
                while (sp > 0)
                begin
                    u = walk_vtx[sp-1];
                    w = lowest_neighbor(edge_rows[u], walk_nxt[sp-1]);
                    if (w >= NV)
                        sp--;
                    else
                    begin
                        walk_nxt[sp-1] = w + 1;
                        is_end  = lowest_neighbor(edge_rows[u], w + 1) >= NV;
                        is_tree = !seen_mask[w];
                        rec.from_vertex    = dfsec_pkg::VID_W'(u);
                        rec.to_vertex      = dfsec_pkg::VID_W'(w);
                        rec.tree_edge      = is_tree;
                        rec.depth_level    = dfsec_pkg::DEPTH_W'(sp);
                        rec.root_group_end = (sp == 1) && is_end;
                        rec.last           = 1'b0;
                        if (have_held)
                            expected_edges.insert(expected_edges.size(), held);
                        held = rec;
                        have_held = 1'b1;
                        if (is_tree && sp < NV)
                        begin
                            seen_mask[w] = 1'b1;
                            walk_vtx[sp] = w;
                            walk_nxt[sp] = 0;
                            sp++;
                        end
                    end
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_edges.insert(expected_edges.size(), held);
        end
        // graph and marks clear after every run
        for (int i = 0; i < NV; i++)
            edge_rows[i] = '0;
        seen_mask = '0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int seen_val, input int want_val);
        if (seen_val != want_val)
            report_mismatch($sformatf("word %0d %s got %0d want %0d",
                                      words_seen, name, seen_val, want_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
                edge_rows[i] = '0;
            seen_mask = '0;
            expected_edges.delete();
            words_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.from_vertex    = out_ch.from_vertex;
                got.to_vertex      = out_ch.to_vertex;
                got.tree_edge      = out_ch.tree_edge;
                got.depth_level    = out_ch.depth_level;
                got.root_group_end = out_ch.root_group_end;
                got.last           = out_ch.last;
                if (expected_edges.size() == 0)
                    report_mismatch($sformatf(
                        "word %0d arrived with nothing expected (%0d->%0d)",
                        words_seen, got.from_vertex, got.to_vertex));
                else
                begin
                    want = expected_edges.pop_front();
                    check_field("from_vertex", got.from_vertex, want.from_vertex);
                    check_field("to_vertex", got.to_vertex, want.to_vertex);
                    check_field("tree_edge", got.tree_edge, want.tree_edge);
                    check_field("depth_level", got.depth_level, want.depth_level);
                    check_field("root_group_end", got.root_group_end, want.root_group_end);
                    check_field("last", got.last, want.last);
                end
                words_seen++;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.opcode == dfsec_pkg::OP_ADD_EDGE)
                begin
                    if (in_ch.src_vertex < NV && in_ch.dst_vertex < NV)
                        edge_rows[in_ch.src_vertex][in_ch.dst_vertex] = 1'b1;
                end
                else
                    walk_graph(in_ch.vertex_count);
            end
            pending <= expected_edges.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int NV           = 8;
    localparam int ITEM_GOAL    = 120;
    // long output stall that lets the block fill up and stop taking words
    localparam int HOLD_CYCLES  = 300;
    // drain time after the last expected word; the output holds at most two words
    localparam int DRAIN_CYCLES = 40;
    // the worst case per run word lies far below this watchdog bound
    localparam int CYCLE_LIMIT  = 600000;

    logic clk = 1'b0;
    logic rst_n;

    dfsec_in_if  in_ch ();
    dfsec_out_if out_ch ();

    int fail_count;
    int pending;
    int items_sent;
    int cycle_count;
    int hold_asks;
    bit send_calm;
    bit recv_calm;

    always #2 clk = ~clk;

    dfs_edge_classifier #(
        .MAX_VERTICES (NV)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    dfsec_walk_checker #(
        .NV (NV)
    ) i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle cycles before one word; a calm stretch has none at all.
    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Offer one input word and hold it until the block takes it. Valid stays
    // high after acceptance so a zero gap gives back-to-back words.
    task automatic send_word(input logic op,
                             input logic [dfsec_pkg::VID_W-1:0] src,
                             input logic [dfsec_pkg::VID_W-1:0] dst,
                             input logic [dfsec_pkg::COUNT_W-1:0] cnt);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.src_vertex   <= src;
        in_ch.dst_vertex   <= dst;
        in_ch.vertex_count <= cnt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    // The count field of an edge word is don't-care; randomize it anyway.
    task automatic add_edge(input logic [dfsec_pkg::VID_W-1:0] src,
                            input logic [dfsec_pkg::VID_W-1:0] dst);
        send_word(dfsec_pkg::OP_ADD_EDGE, src, dst,
                  dfsec_pkg::COUNT_W'($urandom_range(0, 15)));
    endtask

    // Vertex fields of a run word are don't-care as well.
    task automatic run_walk(input logic [dfsec_pkg::COUNT_W-1:0] cnt);
        send_word(dfsec_pkg::OP_RUN, dfsec_pkg::VID_W'($urandom_range(0, 7)),
                  dfsec_pkg::VID_W'($urandom_range(0, 7)), cnt);
    endtask

    // Drop valid right at the acceptance edge, then wait out every pending word.
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Watchdog: a leftover expectation or a hung block ends up here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** dfs_edge_classifier: FAILED **");
        $finish;
    end

    // Output side: random ready gaps per word, calm stretches toggled now and
    // then, and one long hold-off when the stimulus asks for it.
    initial
    begin
        int gap;
        int held;
        int hold_served;
        out_ch.ready <= 1'b0;
        recv_calm = 1'b0;
        hold_served = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                out_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            if ($urandom_range(0, 24) == 0)
                recv_calm = ~recv_calm;
            gap = pick_gap(recv_calm);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int n_edges;
        int span;
        logic [dfsec_pkg::VID_W-1:0]   s;
        logic [dfsec_pkg::VID_W-1:0]   d;
        logic [dfsec_pkg::COUNT_W-1:0] cnt;

        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= dfsec_pkg::OP_ADD_EDGE;
        in_ch.src_vertex   <= '0;
        in_ch.dst_vertex   <= '0;
        in_ch.vertex_count <= '0;
        rst_n              <= 1'b0;
        items_sent = 0;
        hold_asks  = 0;
        send_calm  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Corner vertices, two self-loops, a duplicate edge, and an edge 3->5 that
        // sits above the root count of 1 and is never reached.
        add_edge(3'd0, 3'd0);
        add_edge(3'd0, 3'd7);
        add_edge(3'd7, 3'd0);
        add_edge(3'd7, 3'd7);
        add_edge(3'd0, 3'd7);
        add_edge(3'd3, 3'd5);
        run_walk(4'd1);

        // Zero count: nothing walked, but the edge must still be cleared.
        // The following run on an empty graph sends nothing.
        add_edge(3'd2, 3'd4);
        run_walk(4'd0);
        run_walk(4'd5);

        // Full-length chain down to the deepest level, closed back to 0, run
        // with a count above the vertex limit. The receiver takes the first word of
        // this run and then stalls hard while the next words are already offered.
        pause_until_drained();
        for (int i = 0; i < NV - 1; i++)
            add_edge(dfsec_pkg::VID_W'(i), dfsec_pkg::VID_W'(i + 1));
        add_edge(3'd7, 3'd0);
        hold_asks++;
        run_walk(4'd15);

        // Two opposite edges and one more, walked with a count that covers every vertex.
        add_edge(3'd1, 3'd6);
        add_edge(3'd6, 3'd1);
        add_edge(3'd5, 3'd2);
        run_walk(4'd8);

        // Sender goes quiet until the block has handed over every word.
        pause_until_drained();

        // Random graphs, each closed by a run. Endpoints mostly fall in a small
        // vertex span so the graphs are dense enough to descend several levels;
        // a stray run now and then breaks a graph apart.
        while (items_sent < ITEM_GOAL)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            n_edges = $urandom_range(0, 14);
            span = $urandom_range(2, 8);
            for (int i = 0; i < n_edges; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    s = dfsec_pkg::VID_W'($urandom_range(0, 7));
                    d = dfsec_pkg::VID_W'($urandom_range(0, 7));
                end
                else
                begin
                    s = dfsec_pkg::VID_W'($urandom_range(0, span - 1));
                    d = dfsec_pkg::VID_W'($urandom_range(0, span - 1));
                end
                add_edge(s, d);
                if ($urandom_range(0, 19) == 0)
                    run_walk(dfsec_pkg::COUNT_W'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 3) == 0)
                cnt = dfsec_pkg::COUNT_W'($urandom_range(0, 15));
            else
                cnt = dfsec_pkg::COUNT_W'($urandom_range(1, 8));
            run_walk(cnt);
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** dfs_edge_classifier: PASSED **");
        else
            $display("** dfs_edge_classifier: FAILED **");
        $finish;
    end

endmodule
